// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PFC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define PFC_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ----- design/pfc_pkg.sv -----
// Types, constants and helper functions of the Playfair digraph cipher core.
`timescale 1ns / 1ps

package pfc_pkg;

   localparam int SIDE       = 5;
   localparam int CELLS      = SIDE * SIDE;
   localparam int LETTER_W   = 5;
   localparam int IDX_W      = 3;
   localparam int POS_W      = 5;
   localparam int PART_CELLS = 12;
   localparam int CSR_DATA_W = PART_CELLS * LETTER_W;
   localparam int CSR_ADDR_W = 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_SQUARE_LOW  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SQUARE_HIGH = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SQUARE_LAST = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_FILLER      = 2'd3;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   localparam logic [LETTER_W-1:0] FILLER_RESET = 5'd23;

   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [POS_W-1:0]    pos_type;
   typedef logic [CELLS-1:0][LETTER_W-1:0] square_type;

   // Where one letter sits in the square.
   typedef struct packed {
      logic    found;
      idx_type row;
      idx_type col;
   } loc_type;

   // Spread the three key registers over the 25 square positions.
   function automatic square_type unpack_square(
      input logic [CSR_DATA_W-1:0] low_part,
      input logic [CSR_DATA_W-1:0] high_part,
      input letter_type            last_letter
   );
      square_type sq;
      for (int p = 0; p < PART_CELLS; p++) begin
         sq[p]              = low_part[p*LETTER_W +: LETTER_W];
         sq[p + PART_CELLS] = high_part[p*LETTER_W +: LETTER_W];
      end
      sq[CELLS-1] = last_letter;
      return sq;
   endfunction

   // Move one step along a row or column, wrapping at the edge.
   function automatic idx_type step_idx(input idx_type idx, input logic decrypt);
      idx_type res;
      if (decrypt == OP_DECRYPT) begin
         res = (idx == idx_type'(0)) ? idx_type'(SIDE - 1) : idx - idx_type'(1);
      end else begin
         res = (idx == idx_type'(SIDE - 1)) ? idx_type'(0) : idx + idx_type'(1);
      end
      return res;
   endfunction

   // Square position from row and column.
   function automatic pos_type cell_pos(input idx_type row, input idx_type col);
      return pos_type'(row) * pos_type'(SIDE) + pos_type'(col);
   endfunction

endpackage

// ----- design/pfc_locate.sv -----
// Finds the lowest square position that holds a letter, as row and column.
`timescale 1ns / 1ps

module pfc_locate (
   input  pfc_pkg::square_type square,
   input  pfc_pkg::letter_type letter,
   output pfc_pkg::loc_type    loc
);

   // Scan from the last position down so the lowest match is written last.
   always_comb begin
      loc = '0;
      for (int r = pfc_pkg::SIDE - 1; r >= 0; r--) begin
         for (int c = pfc_pkg::SIDE - 1; c >= 0; c--) begin
            if (square[r*pfc_pkg::SIDE + c] == letter) begin
               loc.found = 1'b1;
               loc.row   = pfc_pkg::idx_type'(r);
               loc.col   = pfc_pkg::idx_type'(c);
            end
         end
      end
   end

endmodule

// ----- design/playfair_digraph_cipher_core.sv -----
// Top level of the Playfair digraph cipher core: key square, pipeline, handshakes.
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+--------------------------------------
//  req     | in        | req_valid / req_ready  | opcode, first and second letter
//  rsp     | out       | rsp_valid / rsp_ready  | two letters, two keep flags, not_found
//  csr     | in        | csr_wr_en, no wait     | key square parts and filler letter
//
// One word per cycle while rsp is not stalled; a taken word goes into the input register, then
// through the square search and lookup into the result register, which drives rsp.
// Reset clears both valid bits, the square to all A and the filler to X.
// A stalled rsp holds the result register; req stays ready while the input register
// can advance or is empty, so a stall backs up one stage at a time.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module playfair_digraph_cipher_core (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_opcode,
   input  logic [pfc_pkg::LETTER_W-1:0]        req_first_letter,
   input  logic [pfc_pkg::LETTER_W-1:0]        req_second_letter,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pfc_pkg::LETTER_W-1:0]        rsp_first_out,
   output logic [pfc_pkg::LETTER_W-1:0]        rsp_second_out,
   output logic                                rsp_keep_first,
   output logic                                rsp_keep_second,
   output logic                                rsp_not_found,
   // configuration write port
   input  logic                                csr_wr_en,
   input  logic [pfc_pkg::CSR_ADDR_W-1:0]      csr_index,
   input  logic [pfc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [pfc_pkg::CSR_DATA_W-1:0] sq_low_ff,  sq_low_in;
   logic [pfc_pkg::CSR_DATA_W-1:0] sq_high_ff, sq_high_in;
   pfc_pkg::letter_type            sq_last_ff, sq_last_in;
   pfc_pkg::letter_type            filler_ff,  filler_in;

   always_comb begin
      sq_low_in  = sq_low_ff;
      sq_high_in = sq_high_ff;
      sq_last_in = sq_last_ff;
      filler_in  = filler_ff;
      if (csr_wr_en) begin
         case (csr_index)
            pfc_pkg::CSR_SQUARE_LOW:  sq_low_in  = csr_wdata;
            pfc_pkg::CSR_SQUARE_HIGH: sq_high_in = csr_wdata;
            pfc_pkg::CSR_SQUARE_LAST: sq_last_in = csr_wdata[pfc_pkg::LETTER_W-1:0];
            pfc_pkg::CSR_FILLER:      filler_in  = csr_wdata[pfc_pkg::LETTER_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_low_ff  <= '0;
         sq_high_ff <= '0;
         sq_last_ff <= '0;
         filler_ff  <= pfc_pkg::FILLER_RESET;
      end else begin
         sq_low_ff  <= sq_low_in;
         sq_high_ff <= sq_high_in;
         sq_last_ff <= sq_last_in;
         filler_ff  <= filler_in;
      end
   end

   pfc_pkg::square_type square;
   assign square = pfc_pkg::unpack_square(sq_low_ff, sq_high_ff, sq_last_ff);

   // ---------------------------------------------------------------------
   // Pipeline control: advance the input register when the result register
   // is empty or being drained.
   // ---------------------------------------------------------------------
   logic in_valid_ff,  in_valid_in;
   logic out_valid_ff, out_valid_in;
   logic advance;
   logic take_req;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign take_req  = req_valid && req_ready;

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register: hold the request word until it moves on.
   logic                in_opcode_ff, in_opcode_in;
   pfc_pkg::letter_type in_first_ff,  in_first_in;
   pfc_pkg::letter_type in_second_ff, in_second_in;

   assign in_opcode_in = take_req ? req_opcode        : in_opcode_ff;
   assign in_first_in  = take_req ? req_first_letter  : in_first_ff;
   assign in_second_in = take_req ? req_second_letter : in_second_ff;

   always_ff @(posedge clock) begin
      in_opcode_ff <= in_opcode_in;
      in_first_ff  <= in_first_in;
      in_second_ff <= in_second_in;
   end

   // ---------------------------------------------------------------------
   // Cipher logic: locate both letters, pick the new cells, read them back.
   // ---------------------------------------------------------------------
   pfc_pkg::loc_type loc_a, loc_b;

   pfc_locate u_locate_first (
      .square (square),
      .letter (in_first_ff),
      .loc    (loc_a)
   );

   pfc_locate u_locate_second (
      .square (square),
      .letter (in_second_ff),
      .loc    (loc_b)
   );

   pfc_pkg::idx_type    row_a, col_a, row_b, col_b;
   pfc_pkg::letter_type new_a, new_b;
   logic                missing;
   logic                dec;

   assign dec     = (in_opcode_ff == pfc_pkg::OP_DECRYPT);
   assign missing = !loc_a.found || !loc_b.found;

   always_comb begin
      if (loc_a.row == loc_b.row) begin
         // same row (also the case for a repeated letter): slide along the row
         row_a = loc_a.row;
         row_b = loc_b.row;
         col_a = pfc_pkg::step_idx(loc_a.col, in_opcode_ff);
         col_b = pfc_pkg::step_idx(loc_b.col, in_opcode_ff);
      end else if (loc_a.col == loc_b.col) begin
         // same column: slide along the column
         row_a = pfc_pkg::step_idx(loc_a.row, in_opcode_ff);
         row_b = pfc_pkg::step_idx(loc_b.row, in_opcode_ff);
         col_a = loc_a.col;
         col_b = loc_b.col;
      end else begin
         // rectangle: swap columns, keep rows
         row_a = loc_a.row;
         row_b = loc_b.row;
         col_a = loc_b.col;
         col_b = loc_a.col;
      end
   end

   assign new_a = square[pfc_pkg::cell_pos(row_a, col_a)];
   assign new_b = square[pfc_pkg::cell_pos(row_b, col_b)];

   // Result register: load when the stage advances, hold while stalled.
   pfc_pkg::letter_type out_first_ff,  out_first_in;
   pfc_pkg::letter_type out_second_ff, out_second_in;
   logic                out_keep_a_ff, out_keep_a_in;
   logic                out_keep_b_ff, out_keep_b_in;
   logic                out_miss_ff,   out_miss_in;
   logic                load_out;

   assign load_out = advance && in_valid_ff;

   always_comb begin
      out_first_in  = out_first_ff;
      out_second_in = out_second_ff;
      out_keep_a_in = out_keep_a_ff;
      out_keep_b_in = out_keep_b_ff;
      out_miss_in   = out_miss_ff;
      if (load_out) begin
         if (missing) begin
            // drop the whole pair: zero letters and flags
            out_first_in  = '0;
            out_second_in = '0;
            out_keep_a_in = 1'b0;
            out_keep_b_in = 1'b0;
            out_miss_in   = 1'b1;
         end else begin
            out_first_in  = new_a;
            out_second_in = new_b;
            out_keep_a_in = !(dec && (new_a == filler_ff));
            out_keep_b_in = !(dec && (new_b == filler_ff));
            out_miss_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_first_ff  <= out_first_in;
      out_second_ff <= out_second_in;
      out_keep_a_ff <= out_keep_a_in;
      out_keep_b_ff <= out_keep_b_in;
      out_miss_ff   <= out_miss_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_first_out   = out_first_ff;
   assign rsp_second_out  = out_second_ff;
   assign rsp_keep_first  = out_keep_a_ff;
   assign rsp_keep_second = out_keep_b_ff;
   assign rsp_not_found   = out_miss_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `PFC_ASSERT(a_miss_zero,
      rsp_valid && rsp_not_found |-> rsp_first_out == '0 && rsp_second_out == '0
         && !rsp_keep_first && !rsp_keep_second,
      "not_found word carries nonzero fields")
   `PFC_ASSERT(a_drop_first_is_filler,
      rsp_valid && !rsp_not_found && !rsp_keep_first |-> rsp_first_out == filler_ff,
      "first letter dropped but not the filler")
   `PFC_ASSERT(a_drop_second_is_filler,
      rsp_valid && !rsp_not_found && !rsp_keep_second |-> rsp_second_out == filler_ff,
      "second letter dropped but not the filler")
   `PFC_ASSERT_NEVER(a_ready_only_on_stall,
      !req_ready && !(in_valid_ff && rsp_valid && !rsp_ready),
      "req not ready without a full stalled pipe")

endmodule
